// ===== src/sphere_box_overlap_test_assert.svh =====
// Assertion macros shared by the sphere/box overlap test RTL.
// Each macro expects clk and the active-low synchronous reset rst_n in scope.
`ifndef SPHERE_BOX_OVERLAP_TEST_ASSERT_SVH
`define SPHERE_BOX_OVERLAP_TEST_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define SBO_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define SBO_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/sbo_pkg.sv =====
// Shared widths, types, register indexes and reset values for the
// sphere/box overlap test. No dependencies.
package sbo_pkg;

  localparam int CW    = 32;  // coordinate, signed Q16.16
  localparam int RW    = 31;  // radius and half size, unsigned Q15.16
  localparam int QW    = 16;  // rotation entry, signed Q1.14
  localparam int QFRAC = 14;  // fraction bits of a rotation entry
  localparam int RROW  = 3 * QW;
  localparam int DW    = CW + 1;        // centre difference
  localparam int PW    = QW + DW;       // rotation entry times difference
  localparam int LW    = PW + 2;        // sum of three products
  localparam int ROPW  = RW + 2;        // radius or radius sum
  localparam int RSQW  = 2 * ROPW;      // squared reach operand
  localparam int ELW   = 26;            // low part of a squared operand
  localparam int EHW   = LW - ELW;      // high part of a squared operand
  localparam int HHW   = 2 * EHW;
  localparam int HLW   = EHW + ELW;
  localparam int LLW   = 2 * ELW;
  localparam int SQW   = 2 * LW;        // one squared term
  localparam int DSTW  = SQW + 2;       // sum of three squared terms
  localparam int RSHIFT = 2 * QFRAC;    // Q.32 to Q.60 scaling of r squared
  localparam int RCHW  = 2 * RW + RSHIFT;
  localparam int CFGIW = 3;

  typedef enum logic [CFGIW-1:0] {
    CFG_ROT_ROW0 = 3'd0,
    CFG_ROT_ROW1 = 3'd1,
    CFG_ROT_ROW2 = 3'd2,
    CFG_HALF_X   = 3'd3,
    CFG_HALF_Y   = 3'd4,
    CFG_HALF_Z   = 3'd5
  } cfg_idx_t;

  // Identity rotation after reset.
  localparam logic [RROW-1:0] ROT_ROW0_RST = 48'h0000_0000_4000;
  localparam logic [RROW-1:0] ROT_ROW1_RST = 48'h0000_4000_0000;
  localparam logic [RROW-1:0] ROT_ROW2_RST = 48'h4000_0000_0000;

  typedef logic [2:0][QW-1:0] rot_row_t;
  typedef logic [2:0][RW-1:0] half_set_t;

  typedef struct packed {
    logic                func;
    logic [2:0][CW-1:0]  sphere;
    logic [RW-1:0]       sphere_radius;
    logic [2:0][CW-1:0]  other;
    logic [RW-1:0]       other_radius;
  } query_t;

  // Box-frame coordinates and sphere-mode magnitudes after the rotation stages.
  typedef struct packed {
    logic                func;
    logic [2:0][LW-1:0]  lcl;
    logic [2:0][DW-1:0]  magd;
    logic [RSQW-1:0]     rsq;
  } local_t;

  // Per-axis squared terms and the reach they are compared with.
  typedef struct packed {
    logic [2:0][SQW-1:0] sq;
    logic [RCHW-1:0]     reach;
  } square_t;

endpackage

// ===== src/sbo_local.sv =====
// Front of the pipeline: centre differences, rotation products and box-frame sums.
// Uses sbo_pkg for types and widths.
module sbo_local (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   up_valid,
  output logic                   up_ready,
  input  sbo_pkg::query_t        up_q,
  input  sbo_pkg::rot_row_t [2:0] rot,
  output logic                   dn_valid,
  input  logic                   dn_ready,
  output sbo_pkg::local_t        dn_q
);

  typedef logic signed [sbo_pkg::DW-1:0] diff_t;
  typedef logic signed [sbo_pkg::PW-1:0] prod_t;
  typedef logic signed [sbo_pkg::LW-1:0] lcl_t;

  logic rdy1, rdy2, rdy3;

  logic                       s1_valid_r;
  logic                       s1_func_r;
  diff_t                      s1_d_r   [3];
  diff_t                      d_nxt    [3];
  logic [sbo_pkg::ROPW-1:0]   s1_rop_r;
  logic [sbo_pkg::ROPW-1:0]   rop_nxt;

  logic                       s2_valid_r;
  logic                       s2_func_r;
  prod_t                      s2_prod_r [3][3];
  prod_t                      prod_nxt  [3][3];
  logic [sbo_pkg::DW-1:0]     s2_magd_r [3];
  logic [sbo_pkg::DW-1:0]     magd_nxt  [3];
  logic [sbo_pkg::RSQW-1:0]   s2_rsq_r;
  logic [sbo_pkg::RSQW-1:0]   rsq_nxt;

  logic                       s3_valid_r;
  logic                       s3_func_r;
  lcl_t                       s3_lcl_r  [3];
  lcl_t                       lcl_nxt   [3];
  logic [sbo_pkg::DW-1:0]     s3_magd_r [3];
  logic [sbo_pkg::RSQW-1:0]   s3_rsq_r;

  assign rdy3     = !s3_valid_r || dn_ready;
  assign rdy2     = !s2_valid_r || rdy3;
  assign rdy1     = !s1_valid_r || rdy2;
  assign up_ready = rdy1;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      d_nxt[i] = {up_q.sphere[i][sbo_pkg::CW-1], up_q.sphere[i]}
               - {up_q.other[i][sbo_pkg::CW-1], up_q.other[i]};
    end
    // Box mode compares against r alone, sphere mode against the radius sum.
    if (up_q.func) begin
      rop_nxt = sbo_pkg::ROPW'(up_q.sphere_radius);
    end else begin
      rop_nxt = sbo_pkg::ROPW'(up_q.sphere_radius) + sbo_pkg::ROPW'(up_q.other_radius);
    end
  end

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      for (int i = 0; i < 3; i++) begin
        prod_nxt[j][i] = sbo_pkg::PW'($signed(rot[j][i])) * sbo_pkg::PW'(s1_d_r[i]);
      end
    end
    for (int i = 0; i < 3; i++) begin
      magd_nxt[i] = s1_d_r[i][sbo_pkg::DW-1] ? (~s1_d_r[i] + 1'b1) : s1_d_r[i];
    end
    rsq_nxt = sbo_pkg::RSQW'(s1_rop_r) * sbo_pkg::RSQW'(s1_rop_r);
  end

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      lcl_nxt[j] = sbo_pkg::LW'(s2_prod_r[j][0]) + sbo_pkg::LW'(s2_prod_r[j][1])
                 + sbo_pkg::LW'(s2_prod_r[j][2]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
      s3_valid_r <= 1'b0;
    end else begin
      if (rdy1) begin
        s1_valid_r <= up_valid;
      end
      if (rdy2) begin
        s2_valid_r <= s1_valid_r;
      end
      if (rdy3) begin
        s3_valid_r <= s2_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1 && up_valid) begin
      s1_func_r <= up_q.func;
      s1_d_r    <= d_nxt;
      s1_rop_r  <= rop_nxt;
    end
    if (rdy2 && s1_valid_r) begin
      s2_func_r <= s1_func_r;
      s2_prod_r <= prod_nxt;
      s2_magd_r <= magd_nxt;
      s2_rsq_r  <= rsq_nxt;
    end
    if (rdy3 && s2_valid_r) begin
      s3_func_r <= s2_func_r;
      s3_lcl_r  <= lcl_nxt;
      s3_magd_r <= s2_magd_r;
      s3_rsq_r  <= s2_rsq_r;
    end
  end

  always_comb begin
    dn_valid = s3_valid_r;
    dn_q.func = s3_func_r;
    dn_q.rsq  = s3_rsq_r;
    for (int j = 0; j < 3; j++) begin
      dn_q.lcl[j]  = s3_lcl_r[j];
      dn_q.magd[j] = s3_magd_r[j];
    end
  end

endmodule

// ===== src/sbo_excess.sv =====
// Middle of the pipeline: per-axis excess beyond the box, split squaring and reach scaling.
// Uses sbo_pkg for types and widths.
module sbo_excess (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                up_valid,
  output logic                up_ready,
  input  sbo_pkg::local_t     up_q,
  input  sbo_pkg::half_set_t  half,
  output logic                dn_valid,
  input  logic                dn_ready,
  output sbo_pkg::square_t    dn_q
);

  logic rdy4, rdy5, rdy6;

  logic [sbo_pkg::LW-1:0]   mag_c [3];
  logic [sbo_pkg::LW-1:0]   h_c   [3];
  logic [sbo_pkg::LW-1:0]   ex_c  [3];

  logic                     s4_valid_r;
  logic                     s4_func_r;
  logic [sbo_pkg::LW-1:0]   s4_e_r [3];
  logic [sbo_pkg::LW-1:0]   e_nxt  [3];
  logic [sbo_pkg::RSQW-1:0] s4_rsq_r;

  logic                     s5_valid_r;
  logic                     s5_func_r;
  logic [sbo_pkg::HHW-1:0]  s5_hh_r [3];
  logic [sbo_pkg::HLW-1:0]  s5_hl_r [3];
  logic [sbo_pkg::LLW-1:0]  s5_ll_r [3];
  logic [sbo_pkg::HHW-1:0]  hh_nxt  [3];
  logic [sbo_pkg::HLW-1:0]  hl_nxt  [3];
  logic [sbo_pkg::LLW-1:0]  ll_nxt  [3];
  logic [sbo_pkg::RSQW-1:0] s5_rsq_r;

  logic                     s6_valid_r;
  logic [sbo_pkg::SQW-1:0]  s6_sq_r  [3];
  logic [sbo_pkg::SQW-1:0]  sq_nxt   [3];
  logic [sbo_pkg::RCHW-1:0] s6_reach_r;
  logic [sbo_pkg::RCHW-1:0] reach_nxt;

  assign rdy6     = !s6_valid_r || dn_ready;
  assign rdy5     = !s5_valid_r || rdy6;
  assign rdy4     = !s4_valid_r || rdy5;
  assign up_ready = rdy4;

  // In box mode the squared operand is the distance outside the slab on each
  // axis; in sphere mode it is simply the centre difference magnitude.
  always_comb begin
    for (int j = 0; j < 3; j++) begin
      mag_c[j] = up_q.lcl[j][sbo_pkg::LW-1] ? (~up_q.lcl[j] + 1'b1) : up_q.lcl[j];
      h_c[j]   = sbo_pkg::LW'({half[j], {sbo_pkg::QFRAC{1'b0}}});
      ex_c[j]  = (mag_c[j] > h_c[j]) ? (mag_c[j] - h_c[j]) : '0;
      e_nxt[j] = up_q.func ? ex_c[j] : sbo_pkg::LW'(up_q.magd[j]);
    end
  end

  // Each square is built from three partial products of at most 26 x 26 bits.
  always_comb begin
    for (int j = 0; j < 3; j++) begin
      hh_nxt[j] = sbo_pkg::HHW'(s4_e_r[j][sbo_pkg::LW-1:sbo_pkg::ELW])
                * sbo_pkg::HHW'(s4_e_r[j][sbo_pkg::LW-1:sbo_pkg::ELW]);
      hl_nxt[j] = sbo_pkg::HLW'(s4_e_r[j][sbo_pkg::LW-1:sbo_pkg::ELW])
                * sbo_pkg::HLW'(s4_e_r[j][sbo_pkg::ELW-1:0]);
      ll_nxt[j] = sbo_pkg::LLW'(s4_e_r[j][sbo_pkg::ELW-1:0])
                * sbo_pkg::LLW'(s4_e_r[j][sbo_pkg::ELW-1:0]);
    end
  end

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      sq_nxt[j] = {s5_hh_r[j], {(2 * sbo_pkg::ELW){1'b0}}}
                + sbo_pkg::SQW'({s5_hl_r[j], {(sbo_pkg::ELW + 1){1'b0}}})
                + sbo_pkg::SQW'(s5_ll_r[j]);
    end
    if (s5_func_r) begin
      reach_nxt = {s5_rsq_r[2*sbo_pkg::RW-1:0], {sbo_pkg::RSHIFT{1'b0}}};
    end else begin
      reach_nxt = sbo_pkg::RCHW'(s5_rsq_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s4_valid_r <= 1'b0;
      s5_valid_r <= 1'b0;
      s6_valid_r <= 1'b0;
    end else begin
      if (rdy4) begin
        s4_valid_r <= up_valid;
      end
      if (rdy5) begin
        s5_valid_r <= s4_valid_r;
      end
      if (rdy6) begin
        s6_valid_r <= s5_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy4 && up_valid) begin
      s4_func_r <= up_q.func;
      s4_e_r    <= e_nxt;
      s4_rsq_r  <= up_q.rsq;
    end
    if (rdy5 && s4_valid_r) begin
      s5_func_r <= s4_func_r;
      s5_hh_r   <= hh_nxt;
      s5_hl_r   <= hl_nxt;
      s5_ll_r   <= ll_nxt;
      s5_rsq_r  <= s4_rsq_r;
    end
    if (rdy6 && s5_valid_r) begin
      s6_sq_r    <= sq_nxt;
      s6_reach_r <= reach_nxt;
    end
  end

  always_comb begin
    dn_valid   = s6_valid_r;
    dn_q.reach = s6_reach_r;
    for (int j = 0; j < 3; j++) begin
      dn_q.sq[j] = s6_sq_r[j];
    end
  end

endmodule

// ===== src/sbo_compare.sv =====
// Back of the pipeline: sum of squared terms, compare with reach, output register.
// Uses sbo_pkg for types and widths.
module sbo_compare (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              up_valid,
  output logic              up_ready,
  input  sbo_pkg::square_t  up_q,
  output logic              dn_valid,
  input  logic              dn_ready,
  output logic              dn_separated
);

  logic rdy7, rdy8;

  logic                      s7_valid_r;
  logic [sbo_pkg::DSTW-1:0]  s7_dist_r;
  logic [sbo_pkg::DSTW-1:0]  dist_nxt;
  logic [sbo_pkg::RCHW-1:0]  s7_reach_r;

  logic                      s8_valid_r;
  logic                      s8_sep_r;
  logic                      sep_nxt;

  assign rdy8     = !s8_valid_r || dn_ready;
  assign rdy7     = !s7_valid_r || rdy8;
  assign up_ready = rdy7;

  assign dist_nxt = sbo_pkg::DSTW'(up_q.sq[0]) + sbo_pkg::DSTW'(up_q.sq[1])
                  + sbo_pkg::DSTW'(up_q.sq[2]);

  // Touching counts as overlap, so only a strictly larger distance separates.
  assign sep_nxt = s7_dist_r > sbo_pkg::DSTW'(s7_reach_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s7_valid_r <= 1'b0;
      s8_valid_r <= 1'b0;
    end else begin
      if (rdy7) begin
        s7_valid_r <= up_valid;
      end
      if (rdy8) begin
        s8_valid_r <= s7_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy7 && up_valid) begin
      s7_dist_r  <= dist_nxt;
      s7_reach_r <= up_q.reach;
    end
    if (rdy8 && s7_valid_r) begin
      s8_sep_r <= sep_nxt;
    end
  end

  assign dn_valid     = s8_valid_r;
  assign dn_separated = s8_sep_r;

endmodule

// ===== src/sphere_box_overlap_test.sv =====
// Throughput: one item per cycle, no gaps, while out_ready stays high.
// Eight register stages: difference, rotation multiply, axis sum, excess, partial
// products, square assembly, distance sum, and compare with output register; each
// holds its item under backpressure. Synchronous active-low reset empties the
// pipeline, loads the identity rotation and zero half sizes; cfg is always ready.
`include "sphere_box_overlap_test_assert.svh"

module sphere_box_overlap_test (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic                              in_func,
  input  logic signed [sbo_pkg::CW-1:0]     in_sphere_x,
  input  logic signed [sbo_pkg::CW-1:0]     in_sphere_y,
  input  logic signed [sbo_pkg::CW-1:0]     in_sphere_z,
  input  logic        [sbo_pkg::RW-1:0]     in_sphere_radius,
  input  logic signed [sbo_pkg::CW-1:0]     in_other_x,
  input  logic signed [sbo_pkg::CW-1:0]     in_other_y,
  input  logic signed [sbo_pkg::CW-1:0]     in_other_z,
  input  logic        [sbo_pkg::RW-1:0]     in_other_radius,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic                              out_separated,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic        [sbo_pkg::CFGIW-1:0]  cfg_index,
  input  logic        [sbo_pkg::RROW-1:0]   cfg_data
);

  logic [sbo_pkg::RROW-1:0] rot_row0_r, rot_row1_r, rot_row2_r;
  sbo_pkg::half_set_t       half_r;
  sbo_pkg::rot_row_t [2:0]  rot;
  sbo_pkg::query_t          query;

  logic                     loc_valid, loc_ready;
  sbo_pkg::local_t          loc_q;
  logic                     sq_valid, sq_ready;
  sbo_pkg::square_t         sq_q;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rot_row0_r <= sbo_pkg::ROT_ROW0_RST;
      rot_row1_r <= sbo_pkg::ROT_ROW1_RST;
      rot_row2_r <= sbo_pkg::ROT_ROW2_RST;
      half_r     <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        sbo_pkg::CFG_ROT_ROW0: rot_row0_r <= cfg_data;
        sbo_pkg::CFG_ROT_ROW1: rot_row1_r <= cfg_data;
        sbo_pkg::CFG_ROT_ROW2: rot_row2_r <= cfg_data;
        sbo_pkg::CFG_HALF_X:   half_r[0]  <= cfg_data[sbo_pkg::RW-1:0];
        sbo_pkg::CFG_HALF_Y:   half_r[1]  <= cfg_data[sbo_pkg::RW-1:0];
        sbo_pkg::CFG_HALF_Z:   half_r[2]  <= cfg_data[sbo_pkg::RW-1:0];
        default: ;
      endcase
    end
  end

  assign rot[0] = rot_row0_r;
  assign rot[1] = rot_row1_r;
  assign rot[2] = rot_row2_r;

  always_comb begin
    query.func          = in_func;
    query.sphere[0]     = in_sphere_x;
    query.sphere[1]     = in_sphere_y;
    query.sphere[2]     = in_sphere_z;
    query.sphere_radius = in_sphere_radius;
    query.other[0]      = in_other_x;
    query.other[1]      = in_other_y;
    query.other[2]      = in_other_z;
    query.other_radius  = in_other_radius;
  end

  sbo_local u_local (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (in_valid),
    .up_ready (in_ready),
    .up_q     (query),
    .rot      (rot),
    .dn_valid (loc_valid),
    .dn_ready (loc_ready),
    .dn_q     (loc_q)
  );

  sbo_excess u_excess (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (loc_valid),
    .up_ready (loc_ready),
    .up_q     (loc_q),
    .half     (half_r),
    .dn_valid (sq_valid),
    .dn_ready (sq_ready),
    .dn_q     (sq_q)
  );

  sbo_compare u_compare (
    .clk          (clk),
    .rst_n        (rst_n),
    .up_valid     (sq_valid),
    .up_ready     (sq_ready),
    .up_q         (sq_q),
    .dn_valid     (out_valid),
    .dn_ready     (out_ready),
    .dn_separated (out_separated)
  );

  // A write to rotation row 0 must land in that row on the next cycle.
  `SBO_ASSERT_NEXT(a_rot0_write, cfg_valid && cfg_ready && (cfg_index == sbo_pkg::CFG_ROT_ROW0), rot_row0_r == $past(cfg_data), "rotation row 0 write not applied")
  // Half size writes keep only the low register bits.
  `SBO_ASSERT_NEXT(a_halfz_write, cfg_valid && cfg_ready && (cfg_index == sbo_pkg::CFG_HALF_Z), half_r[2] == $past(cfg_data[sbo_pkg::RW-1:0]), "half size z write not applied")
  // With the output register empty every stage can advance, so input must be open.
  `SBO_ASSERT_NOW(a_ready_when_drained, !out_valid, in_ready, "input blocked with empty output")

endmodule
